[rtl/core/lpr_pkg.sv]
// Shared types, sizes and codes for the longest-prefix route table.
package lpr_pkg;

   // Table capacity and the sizes that follow from it.
   localparam int MAX_ROUTES = 64;
   localparam int COUNT_W    = $clog2(MAX_ROUTES + 1);
   localparam int TREE_DEPTH = $clog2(MAX_ROUTES);
   localparam int N_LEAF     = 2 ** TREE_DEPTH;
   localparam int SCAN_W     = $clog2(TREE_DEPTH + 1);

   // Action codes of an input item.
   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // Status codes of a result item.
   localparam logic [1:0] ST_ADDED   = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_FOUND   = 2'd2;
   localparam logic [1:0] ST_NOROUTE = 2'd3;

   // Input item.
   typedef struct packed {
      logic        action;
      logic [31:0] address;
      logic [31:0] net_mask;
      logic [5:0]  prefix_len;
      logic [15:0] port_in;
      logic [31:0] gateway_in;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] port_out;
      logic [31:0] gateway_out;
   } rsp_type;

   // One stored route.
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [5:0]  prefix;
      logic [15:0] port;
      logic [31:0] gateway;
   } entry_type;

   // Match result of one cell, as it enters the selection tree.
   typedef struct packed {
      logic        hit;
      logic [15:0] port;
      logic [31:0] gateway;
   } leaf_type;

endpackage

[rtl/core/lpr_cell.sv]
// One route cell: holds an entry, shifts on insert and reports a lookup match.
module lpr_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              insert,
   input  lpr_pkg::entry_type new_entry,
   input  logic              prev_valid,
   input  lpr_pkg::entry_type prev_entry,
   input  logic [31:0]       lookup_addr,
   output logic              valid,
   output lpr_pkg::entry_type entry,
   output lpr_pkg::leaf_type  leaf
);
   import lpr_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   entry_type entry_in;
   logic      take_prev;
   logic      prev_keeps;
   logic      take_new;

   // Entries with a shorter prefix than the new route move one cell down; the
   // new route lands in the first cell that is empty or whose entry moves down.
   always_comb begin
      take_prev  = insert && prev_valid && (prev_entry.prefix < new_entry.prefix);
      prev_keeps = prev_valid && !(prev_entry.prefix < new_entry.prefix);
      take_new   = insert && prev_keeps && (!valid_ff || (entry_ff.prefix < new_entry.prefix));
      valid_in   = valid_ff || take_prev || take_new;
      entry_in   = entry_ff;
      if (take_prev) begin
         entry_in = prev_entry;
      end else if (take_new) begin
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Match against the broadcast lookup address.
   always_comb begin
      leaf.hit     = valid_ff && ((lookup_addr & entry_ff.mask) == entry_ff.dest);
      leaf.port    = entry_ff.port;
      leaf.gateway = (entry_ff.gateway != 32'd0) ? entry_ff.gateway : lookup_addr;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

[rtl/core/lpr_tree.sv]
// Registered selection tree that picks the first matching cell in list order.
module lpr_tree (
   input  logic              clock,
   input  lpr_pkg::leaf_type leaves [lpr_pkg::MAX_ROUTES],
   output lpr_pkg::leaf_type root
);
   import lpr_pkg::*;

   leaf_type leaf_ff [MAX_ROUTES];
   leaf_type node_ff [N_LEAF-1:1];
   leaf_type child_w [2*N_LEAF-1:2];

   // Leaf stage registers the match of every cell.
   always_ff @(posedge clock) begin
      leaf_ff <= leaves;
   end

   // Children of each node: upper nodes, leaves, or an empty pad leaf.
   for (genvar c = 2; c < 2 * N_LEAF; c++) begin : g_child
      if (c >= N_LEAF) begin : g_leaf
         if (c - N_LEAF < MAX_ROUTES) begin : g_real
            assign child_w[c] = leaf_ff[c-N_LEAF];
         end else begin : g_pad
            assign child_w[c] = '0;
         end
      end else begin : g_node
         assign child_w[c] = node_ff[c];
      end
   end

   // Each node keeps the left child when it hits, since it is earlier in the list.
   for (genvar k = 1; k < N_LEAF; k++) begin : g_node_reg
      always_ff @(posedge clock) begin
         node_ff[k] <= child_w[2*k].hit ? child_w[2*k] : child_w[2*k+1];
      end
   end

   assign root = node_ff[1];

endmodule

[rtl/core/longest_prefix_route_table.sv]
// Top level of the longest-prefix route table: control, cell chain and output register.
// An add item passes from the run state to the done state; a lookup item also waits
// in the scan state for the result of the registered selection tree.
// One item is worked on at a time; the next one is accepted once the result is queued.
// A waiting result in the output register does not block acceptance of the next item.
// Synchronous reset empties the table and clears the state, fill count and output valid.
module longest_prefix_route_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lpr_pkg::rsp_type rsp_data
);
   import lpr_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]         state_ff;
   logic [1:0]         state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [SCAN_W-1:0]  scan_ff;
   logic [SCAN_W-1:0]  scan_in;
   req_type            req_ff;
   req_type            req_in;
   rsp_type            res_ff;
   rsp_type            res_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   logic               accept;
   logic               out_free;
   logic               is_full;
   logic               insert;
   entry_type          new_entry;
   entry_type          head_entry;
   logic [MAX_ROUTES-1:0] cell_valid;
   entry_type          cell_entry [MAX_ROUTES];
   leaf_type           cell_leaf  [MAX_ROUTES];
   leaf_type           root;

   // Handshake and insert strobe.
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      accept    = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      is_full   = (count_ff == COUNT_W'(MAX_ROUTES));
      insert    = (state_ff == S_RUN) && (req_ff.action == ACT_ADD) && !is_full;
   end

   // The stored destination is masked on the way in.
   always_comb begin
      new_entry.dest    = req_ff.address & req_ff.net_mask;
      new_entry.mask    = req_ff.net_mask;
      new_entry.prefix  = req_ff.prefix_len;
      new_entry.port    = req_ff.port_in;
      new_entry.gateway = req_ff.gateway_in;
   end

   // Above the first cell sits a virtual entry with the longest prefix, which never moves.
   always_comb begin
      head_entry        = '0;
      head_entry.prefix = '1;
   end

   // Chain of route cells, each fed by its upper neighbor.
   for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
      if (i == 0) begin : g_head
         lpr_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .insert      (insert),
            .new_entry   (new_entry),
            .prev_valid  (1'b1),
            .prev_entry  (head_entry),
            .lookup_addr (req_ff.address),
            .valid       (cell_valid[i]),
            .entry       (cell_entry[i]),
            .leaf        (cell_leaf[i])
         );
      end else begin : g_body
         lpr_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .insert      (insert),
            .new_entry   (new_entry),
            .prev_valid  (cell_valid[i-1]),
            .prev_entry  (cell_entry[i-1]),
            .lookup_addr (req_ff.address),
            .valid       (cell_valid[i]),
            .entry       (cell_entry[i]),
            .leaf        (cell_leaf[i])
         );
      end
   end

   lpr_tree u_tree (
      .clock  (clock),
      .leaves (cell_leaf),
      .root   (root)
   );

   // Sequencer: take an item, insert or scan, then hand the result to the output register.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (req_ff.action == ACT_ADD) begin
               res_in.status      = is_full ? ST_FULL : ST_ADDED;
               res_in.port_out    = 16'd0;
               res_in.gateway_out = 32'd0;
               if (insert) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               state_in = S_DONE;
            end else begin
               scan_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + SCAN_W'(1);
            if (scan_ff == SCAN_W'(TREE_DEPTH)) begin
               if (root.hit) begin
                  res_in.status      = ST_FOUND;
                  res_in.port_out    = root.port;
                  res_in.gateway_out = root.gateway;
               end else begin
                  res_in.status      = ST_NOROUTE;
                  res_in.port_out    = 16'd0;
                  res_in.gateway_out = 32'd0;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The fill count always equals the number of occupied cells.
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count_ff))
      else $error("entry count differs from occupied cells");

   // An insert never happens into a full table.
   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      insert |-> (count_ff < COUNT_W'(MAX_ROUTES)))
      else $error("insert into full table");

   // Each insert grows the table by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      insert |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("insert did not grow the table by one");

   // Only a found route carries a port and next hop.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != ST_FOUND))
         |-> (rsp_data_ff.port_out == 16'd0) && (rsp_data_ff.gateway_out == 32'd0))
      else $error("non-match result carries route data");

   // An accepted item moves the idle sequencer into the run state.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_RUN))
      else $error("accepted item did not start work");

endmodule
